// ----- rtl/tpm_pkg.sv -----
// Package: shared types, codes and helpers of the typed-text phrase matcher
`timescale 1ns / 1ps
`default_nettype none
package tpm_pkg;

    localparam logic [2:0] ACT_CHAR      = 3'd0;
    localparam logic [2:0] ACT_TICK      = 3'd1;
    localparam logic [2:0] ACT_START     = 3'd2;
    localparam logic [2:0] ACT_PHRASE_WR = 3'd3;
    localparam logic [2:0] ACT_END_WR    = 3'd4;

    localparam logic [2:0] ST_OFF     = 3'd0;
    localparam logic [2:0] ST_RUN     = 3'd1;
    localparam logic [2:0] ST_ENDCHAR = 3'd2;
    localparam logic [2:0] ST_MATCH   = 3'd3;
    localparam logic [2:0] ST_LIMIT   = 3'd4;
    localparam logic [2:0] ST_TIMEOUT = 3'd5;

    localparam logic [2:0] CFG_CASE_SENSITIVE = 3'd0;
    localparam logic [2:0] CFG_FIND_ANYWHERE  = 3'd1;
    localparam logic [2:0] CFG_BUFFER_LIMIT   = 3'd2;
    localparam logic [2:0] CFG_PHRASE_COUNT   = 3'd3;
    localparam logic [2:0] CFG_END_CHAR_COUNT = 3'd4;
    localparam logic [2:0] CFG_TIMEOUT_MS     = 3'd5;

    localparam logic [23:0] ELAPSED_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] char_code;
        logic       batch_last;
        logic [3:0] slot;
        logic [4:0] position;
        logic       phrase_end;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] matched_phrase;
        logic [7:0] ending_char;
        logic [8:0] collected_length;
    } out_item_t;

    // Fold upper-case ASCII to lower case unless comparing exactly
    function automatic logic [7:0] fold(input logic [7:0] c, input logic exact);
        logic [7:0] r;
        r = c;
        if (!exact && c >= 8'h41 && c <= 8'h5A)
            r = c + 8'h20;
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/tpm_ram.sv -----
// Single-port-write, single-port-read synchronous RAM with registered read
`timescale 1ns / 1ps
`default_nettype none
module tpm_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int W     = 8
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [W-1:0]  wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [W-1:0]  rdata
);
    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/typed_text_phrase_matcher_core.sv -----
// Top level: typed-text phrase matcher with sequencer, tables and buffer RAMs
// Flow: ticks, starts and table writes go from idle to the done state, which loads
// the result register; a typed character first scans the end-character slots and is
// then collected; a phrase check steps through phrase select, read issue and compare
// for every phrase tried and every compared character pair over all offsets.
// Throughput: one transaction at a time; the next is taken once the sequencer idles.
// Reset: rst_n asynchronous low; status off, length, timer and ending fields clear.
`timescale 1ns / 1ps
`default_nettype none
module typed_text_phrase_matcher_core #(
    parameter int BUF_DEPTH  = 256,
    parameter int PHRASES    = 16,
    parameter int PHRASE_LEN = 32,
    parameter int END_CHARS  = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire tpm_pkg::in_item_t in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output tpm_pkg::out_item_t    out_data,
    input  wire logic             cfg_we,
    input  wire logic [2:0]       cfg_addr,
    input  wire logic [23:0]      cfg_data
);
    // Widths derived from the sizing parameters
    localparam int TLW = $clog2(BUF_DEPTH + 1);
    localparam int TAW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int PIW = (PHRASES > 1) ? $clog2(PHRASES) : 1;
    localparam int PCW = $clog2(PHRASES + 1);
    localparam int KW  = (PHRASE_LEN > 1) ? $clog2(PHRASE_LEN) : 1;
    localparam int KCW = $clog2(PHRASE_LEN + 1);
    localparam int EIW = (END_CHARS > 1) ? $clog2(END_CHARS) : 1;
    localparam int ECW = $clog2(END_CHARS + 1);
    localparam int PAW = PIW + KW;

    typedef enum logic [2:0] {
        S_IDLE, S_ECHK, S_PSEL, S_RD, S_CMP, S_DONE
    } state_t;

    // Configuration registers
    logic        case_sensitive_reg;
    logic        find_anywhere_reg;
    logic [8:0]  buffer_limit_reg;
    logic [4:0]  phrase_count_reg;
    logic [4:0]  end_char_count_reg;
    logic [23:0] timeout_ms_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            case_sensitive_reg <= 1'b0;
            find_anywhere_reg  <= 1'b0;
            buffer_limit_reg   <= 9'd256;
            phrase_count_reg   <= 5'd0;
            end_char_count_reg <= 5'd0;
            timeout_ms_reg     <= 24'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                tpm_pkg::CFG_CASE_SENSITIVE: case_sensitive_reg <= cfg_data[0];
                tpm_pkg::CFG_FIND_ANYWHERE:  find_anywhere_reg  <= cfg_data[0];
                tpm_pkg::CFG_BUFFER_LIMIT:   buffer_limit_reg   <= cfg_data[8:0];
                tpm_pkg::CFG_PHRASE_COUNT:   phrase_count_reg   <= cfg_data[4:0];
                tpm_pkg::CFG_END_CHAR_COUNT: end_char_count_reg <= cfg_data[4:0];
                tpm_pkg::CFG_TIMEOUT_MS:     timeout_ms_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective limits: cap the register values at the table and buffer sizes
    logic [TLW-1:0] lim;
    logic [PCW-1:0] n_phr;
    logic [ECW-1:0] n_ec;
    assign lim   = (32'(buffer_limit_reg) > BUF_DEPTH) ? TLW'(BUF_DEPTH)
                                                       : TLW'(buffer_limit_reg);
    assign n_phr = (32'(phrase_count_reg) > PHRASES) ? PCW'(PHRASES)
                                                     : PCW'(phrase_count_reg);
    assign n_ec  = (32'(end_char_count_reg) > END_CHARS) ? ECW'(END_CHARS)
                                                         : ECW'(end_char_count_reg);

    // Sequencer and run state
    state_t         state_reg, state_next;
    logic [2:0]     status_reg, status_next;
    logic [TLW-1:0] tlen_reg, tlen_next;
    logic [23:0]    elapsed_reg, elapsed_next;
    logic [3:0]     eidx_reg, eidx_next;
    logic [7:0]     echar_reg, echar_next;
    logic [7:0]     ch_reg, ch_next;
    logic           last_reg, last_next;
    logic [ECW-1:0] ei_reg, ei_next;
    logic [PCW-1:0] p_reg, p_next;
    logic [TLW-1:0] off_reg, off_next;
    logic [KCW-1:0] k_reg, k_next;
    logic [KCW-1:0] plen_reg, plen_next;
    logic           out_valid_reg, out_valid_next;
    tpm_pkg::out_item_t out_data_reg, out_data_next;

    // Small tables, each read at a single sequencer-chosen index
    logic [KCW-1:0] plen_tab [PHRASES];
    logic [7:0]     ec_tab [END_CHARS];

    logic           accept;
    logic           phr_wr_ok, ec_wr_ok;
    logic [PIW-1:0] wslot;
    logic [EIW-1:0] wec;
    logic           txt_we;
    logic [TAW-1:0] txt_waddr, txt_raddr;
    logic [7:0]     txt_rdata, phr_rdata;
    logic [PAW-1:0] phr_waddr, phr_raddr;
    logic [KCW-1:0] cur_len;
    logic [23:0]    el_inc;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign phr_wr_ok = accept && (in_data.action == tpm_pkg::ACT_PHRASE_WR)
                       && (32'(in_data.slot) < PHRASES)
                       && (32'(in_data.position) < PHRASE_LEN);
    assign ec_wr_ok  = accept && (in_data.action == tpm_pkg::ACT_END_WR)
                       && (32'(in_data.slot) < END_CHARS);
    assign wslot     = PIW'(in_data.slot);
    assign wec       = EIW'(in_data.slot);
    assign phr_waddr = {wslot, KW'(in_data.position)};
    assign phr_raddr = {p_reg[PIW-1:0], k_reg[KW-1:0]};
    assign txt_raddr = TAW'(32'(off_reg) + 32'(k_reg));
    assign txt_waddr = TAW'(tlen_reg);
    assign cur_len   = plen_tab[p_reg[PIW-1:0]];
    assign el_inc    = (elapsed_reg != tpm_pkg::ELAPSED_MAX) ? elapsed_reg + 24'd1
                                                            : elapsed_reg;

    // Append the character once it has cleared the end-character scan
    assign txt_we = (state_reg == S_ECHK) && (ei_reg >= n_ec)
                    && (lim != '0) && (tlen_reg < lim);

    always_ff @(posedge clk)
    begin
        if (phr_wr_ok && in_data.phrase_end)
        begin
            plen_tab[wslot] <= KCW'(32'(in_data.position) + 1);
        end
        if (ec_wr_ok)
        begin
            ec_tab[wec] <= in_data.char_code;
        end
    end

    tpm_ram #(.DEPTH(BUF_DEPTH), .AW(TAW), .W(8)) u_text (
        .clk   (clk),
        .we    (txt_we),
        .waddr (txt_waddr),
        .wdata (ch_reg),
        .raddr (txt_raddr),
        .rdata (txt_rdata)
    );

    tpm_ram #(.DEPTH(2 ** PAW), .AW(PAW), .W(8)) u_phrase (
        .clk   (clk),
        .we    (phr_wr_ok),
        .waddr (phr_waddr),
        .wdata (in_data.char_code),
        .raddr (phr_raddr),
        .rdata (phr_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        status_next    = status_reg;
        tlen_next      = tlen_reg;
        elapsed_next   = elapsed_reg;
        eidx_next      = eidx_reg;
        echar_next     = echar_reg;
        ch_next        = ch_reg;
        last_next      = last_reg;
        ei_next        = ei_reg;
        p_next         = p_reg;
        off_next       = off_reg;
        k_next         = k_reg;
        plen_next      = plen_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DONE;
                    case (in_data.action)
                        tpm_pkg::ACT_CHAR:
                        begin
                            if (status_reg == tpm_pkg::ST_RUN)
                            begin
                                ch_next    = in_data.char_code;
                                last_next  = in_data.batch_last;
                                ei_next    = '0;
                                state_next = S_ECHK;
                            end
                        end
                        tpm_pkg::ACT_TICK:
                        begin
                            if (status_reg == tpm_pkg::ST_RUN && timeout_ms_reg != '0)
                            begin
                                elapsed_next = el_inc;
                                if (el_inc >= timeout_ms_reg)
                                    status_next = tpm_pkg::ST_TIMEOUT;
                            end
                        end
                        tpm_pkg::ACT_START:
                        begin
                            tlen_next    = '0;
                            elapsed_next = '0;
                            eidx_next    = '0;
                            echar_next   = '0;
                            status_next  = tpm_pkg::ST_RUN;
                        end
                        default: ;
                    endcase
                end
            end

            // Scan end characters one slot a cycle
            S_ECHK:
            begin
                if (ei_reg < n_ec)
                begin
                    if (tpm_pkg::fold(ec_tab[ei_reg[EIW-1:0]], case_sensitive_reg)
                        == tpm_pkg::fold(ch_reg, case_sensitive_reg))
                    begin
                        echar_next  = ch_reg;
                        status_next = tpm_pkg::ST_ENDCHAR;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        ei_next = ei_reg + 1'b1;
                    end
                end
                else if (lim == '0)
                begin
                    state_next = S_DONE;
                end
                else if (tlen_reg >= lim)
                begin
                    // Full: drop the character and check phrases
                    p_next     = '0;
                    state_next = S_PSEL;
                end
                else
                begin
                    tlen_next  = tlen_reg + 1'b1;
                    p_next     = '0;
                    state_next = last_reg ? S_PSEL : S_DONE;
                end
            end

            // Pick the next phrase that can possibly fit the buffer
            S_PSEL:
            begin
                if (p_reg >= n_phr)
                begin
                    if (tlen_reg >= lim)
                        status_next = tpm_pkg::ST_LIMIT;
                    state_next = S_DONE;
                end
                else if (cur_len != '0 && 32'(cur_len) <= 32'(tlen_reg)
                         && (find_anywhere_reg || 32'(cur_len) == 32'(tlen_reg)))
                begin
                    plen_next  = cur_len;
                    off_next   = '0;
                    k_next     = '0;
                    state_next = S_RD;
                end
                else
                begin
                    p_next = p_reg + 1'b1;
                end
            end

            S_RD:
            begin
                state_next = S_CMP;
            end

            S_CMP:
            begin
                if (tpm_pkg::fold(txt_rdata, case_sensitive_reg)
                    == tpm_pkg::fold(phr_rdata, case_sensitive_reg))
                begin
                    if (k_reg + 1'b1 == plen_reg)
                    begin
                        eidx_next   = 4'(p_reg);
                        status_next = tpm_pkg::ST_MATCH;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
                else if (find_anywhere_reg
                         && (32'(off_reg) + 32'(plen_reg) < 32'(tlen_reg)))
                begin
                    off_next   = off_reg + 1'b1;
                    k_next     = '0;
                    state_next = S_RD;
                end
                else
                begin
                    p_next     = p_reg + 1'b1;
                    state_next = S_PSEL;
                end
            end

            // Hold until the result register is free, then load it
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.status = status_reg;
                    out_data_next.matched_phrase =
                        (status_reg == tpm_pkg::ST_MATCH) ? eidx_reg : 4'd0;
                    out_data_next.ending_char =
                        (status_reg == tpm_pkg::ST_ENDCHAR) ? echar_reg : 8'd0;
                    out_data_next.collected_length = 9'(tlen_reg);
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            status_reg    <= tpm_pkg::ST_OFF;
            tlen_reg      <= '0;
            elapsed_reg   <= '0;
            eidx_reg      <= '0;
            echar_reg     <= '0;
            ei_reg        <= '0;
            p_reg         <= '0;
            off_reg       <= '0;
            k_reg         <= '0;
            plen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            tlen_reg      <= tlen_next;
            elapsed_reg   <= elapsed_next;
            eidx_reg      <= eidx_next;
            echar_reg     <= echar_next;
            ei_reg        <= ei_next;
            p_reg         <= p_next;
            off_reg       <= off_next;
            k_reg         <= k_next;
            plen_reg      <= plen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg       <= ch_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
    end

    // Buffer never holds more characters than it has entries
    a_tlen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(tlen_reg) <= BUF_DEPTH)
        else $error("buffer length beyond depth");

    // Phrase index only reported with a match status
    a_match_field: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != tpm_pkg::ST_MATCH
        |-> out_data.matched_phrase == 4'd0)
        else $error("matched phrase without match status");

    // A compare step always follows a read issue
    a_cmp_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RD |=> state_reg == S_CMP)
        else $error("compare not after read");

endmodule
`default_nettype wire

// ----- sim/tb_typed_text_phrase_matcher_core.sv -----
// Testbench for typed_text_phrase_matcher_core: predicted status per transaction, random idling
`timescale 1ns / 1ps
`default_nettype none
module tb_typed_text_phrase_matcher_core;

    // Actions 5 to 7 have no effect; build them from the first one
    localparam logic [2:0] ACT_UNUSED = 3'd5;
    localparam logic [23:0] TIMER_MAX = 24'hFFFFFF;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    tpm_pkg::in_item_t   in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    tpm_pkg::out_item_t  out_data;
    logic                cfg_we = 1'b0;
    logic [2:0]          cfg_addr = '0;
    logic [23:0]         cfg_data = '0;

    typed_text_phrase_matcher_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow copy of the matcher: registers, tables, buffer and run state
    logic        exact_cmp = 1'b0;
    logic        anywhere = 1'b0;
    int          limit_reg = 256;
    int          phrase_num = 0;
    int          end_num = 0;
    logic [23:0] timeout_reg = '0;

    logic [7:0]  text_mem [256];
    int          text_len = 0;
    logic [7:0]  phrase_mem [16][32];
    int          phrase_len [16];
    logic [7:0]  end_mem [16];
    logic [2:0]  run_state = tpm_pkg::ST_OFF;
    logic [23:0] elapsed = '0;
    logic [3:0]  hit_index = '0;
    logic [7:0]  hit_char = '0;

    tpm_pkg::in_item_t   pending_items [$];
    tpm_pkg::out_item_t  expected_status [$];
    int          mismatches = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          stall_mode = 0;
    int          stall_timer = 0;
    logic        slot_free;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (!exact_cmp && c >= 8'h41 && c <= 8'h5A)
            return c + 8'h20;
        return c;
    endfunction

    function automatic bit phrase_at(input int off, input int p, input int len);
        for (int k = 0; k < len; k++)
            if (to_lower(text_mem[off + k]) != to_lower(phrase_mem[p][k]))
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit phrase_found(input int p);
        int len;
        len = phrase_len[p];
        if (len == 0 || len > text_len)
            return 1'b0;
        if (!anywhere)
            return len == text_len && phrase_at(0, p, len);
        for (int off = 0; off + len <= text_len; off++)
            if (phrase_at(off, p, len))
                return 1'b1;
        return 1'b0;
    endfunction

    // Lowest phrase index wins; no hit ends by limit once the buffer is full
    function automatic void scan_phrases(input int lim);
        int n;
        n = (phrase_num > 16) ? 16 : phrase_num;
        for (int p = 0; p < n; p++)
        begin
            if (phrase_found(p))
            begin
                hit_index = p[3:0];
                run_state = tpm_pkg::ST_MATCH;
                return;
            end
        end
        if (text_len >= lim)
            run_state = tpm_pkg::ST_LIMIT;
    endfunction

    // End characters are tested before the character is collected
    function automatic void collect_char(input logic [7:0] ch, input logic last);
        int n;
        int lim;
        n = (end_num > 16) ? 16 : end_num;
        lim = (limit_reg > 256) ? 256 : limit_reg;
        for (int i = 0; i < n; i++)
        begin
            if (to_lower(end_mem[i]) == to_lower(ch))
            begin
                hit_char = ch;
                run_state = tpm_pkg::ST_ENDCHAR;
                return;
            end
        end
        if (lim == 0)
            return;
        if (text_len >= lim)
        begin
            scan_phrases(lim);
            return;
        end
        text_mem[text_len] = ch;
        text_len++;
        if (last)
            scan_phrases(lim);
    endfunction

    function automatic tpm_pkg::out_item_t matcher_step(input tpm_pkg::in_item_t it);
        tpm_pkg::out_item_t r;
        case (it.action)
            tpm_pkg::ACT_CHAR:
                if (run_state == tpm_pkg::ST_RUN)
                    collect_char(it.char_code, it.batch_last);
            tpm_pkg::ACT_TICK:
                if (run_state == tpm_pkg::ST_RUN && timeout_reg != 0)
                begin
                    if (elapsed < TIMER_MAX)
                        elapsed++;
                    if (elapsed >= timeout_reg)
                        run_state = tpm_pkg::ST_TIMEOUT;
                end
            tpm_pkg::ACT_START:
            begin
                text_len = 0;
                elapsed = '0;
                hit_index = '0;
                hit_char = '0;
                run_state = tpm_pkg::ST_RUN;
            end
            tpm_pkg::ACT_PHRASE_WR:
            begin
                phrase_mem[it.slot][it.position] = it.char_code;
                if (it.phrase_end)
                    phrase_len[it.slot] = int'(it.position) + 1;
            end
            tpm_pkg::ACT_END_WR:
                end_mem[it.slot] = it.char_code;
            default:;
        endcase
        r.status = run_state;
        r.matched_phrase = (run_state == tpm_pkg::ST_MATCH) ? hit_index : 4'd0;
        r.ending_char = (run_state == tpm_pkg::ST_ENDCHAR) ? hit_char : 8'd0;
        r.collected_length = text_len[8:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Driver: send in bursts, hold the transaction while stalled, predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else
        begin
            slot_free = !in_valid || !in_stall;
            if (in_valid && !in_stall)
                expected_status.push_back(matcher_step(in_data));
            if (slot_free)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    in_data <= pending_items.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 20);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted result, stall in modes of no, random or heavy backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_status.size() == 0)
                    report_mismatch("result with nothing expected");
                else
                begin
                    tpm_pkg::out_item_t e;
                    e = expected_status.pop_front();
                    if (out_data.status !== e.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  out_data.status, e.status));
                    if (out_data.matched_phrase !== e.matched_phrase)
                        report_mismatch($sformatf("matched_phrase %0d, expected %0d",
                                                  out_data.matched_phrase, e.matched_phrase));
                    if (out_data.ending_char !== e.ending_char)
                        report_mismatch($sformatf("ending_char %0h, expected %0h",
                                                  out_data.ending_char, e.ending_char));
                    if (out_data.collected_length !== e.collected_length)
                        report_mismatch($sformatf("collected_length %0d, expected %0d",
                                                  out_data.collected_length,
                                                  e.collected_length));
                end
            end
            if (stall_timer == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                stall_timer = $urandom_range(16, 96);
            end
            else
                stall_timer--;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= 1'($urandom_range(0, 1));
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    task automatic queue_item(input logic [2:0] act, input logic [7:0] ch, input logic last,
                              input logic [3:0] slot, input logic [4:0] pos,
                              input logic pend);
        tpm_pkg::in_item_t it;
        it.action = act;
        it.char_code = ch;
        it.batch_last = last;
        it.slot = slot;
        it.position = pos;
        it.phrase_end = pend;
        pending_items.push_back(it);
    endtask

    task automatic queue_char(input logic [7:0] ch, input logic last);
        queue_item(tpm_pkg::ACT_CHAR, ch, last, 4'($urandom), 5'($urandom), 1'($urandom));
    endtask

    task automatic queue_cmd(input logic [2:0] act);
        queue_item(act, 8'($urandom), 1'($urandom), 4'($urandom), 5'($urandom), 1'($urandom));
    endtask

    // Write the phrase characters; the last one sets the length
    task automatic load_phrase(input int slot, input string txt);
        for (int k = 0; k < txt.len(); k++)
            queue_item(tpm_pkg::ACT_PHRASE_WR, txt[k], 1'b0, slot[3:0], k[4:0],
                       k == txt.len() - 1);
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || in_valid || expected_status.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val[23:0];
        case (idx)
            tpm_pkg::CFG_CASE_SENSITIVE: exact_cmp = val[0];
            tpm_pkg::CFG_FIND_ANYWHERE:  anywhere = val[0];
            tpm_pkg::CFG_BUFFER_LIMIT:   limit_reg = val & 'h1FF;
            tpm_pkg::CFG_PHRASE_COUNT:   phrase_num = val & 'h1F;
            tpm_pkg::CFG_END_CHAR_COUNT: end_num = val & 'h1F;
            tpm_pkg::CFG_TIMEOUT_MS:     timeout_reg = val[23:0];
            default:;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(input int cs, input int fa, input int lim, input int pn,
                             input int en, input int tmo);
        write_reg(tpm_pkg::CFG_CASE_SENSITIVE, cs);
        write_reg(tpm_pkg::CFG_FIND_ANYWHERE, fa);
        write_reg(tpm_pkg::CFG_BUFFER_LIMIT, lim);
        write_reg(tpm_pkg::CFG_PHRASE_COUNT, pn);
        write_reg(tpm_pkg::CFG_END_CHAR_COUNT, en);
        write_reg(tpm_pkg::CFG_TIMEOUT_MS, tmo);
    endtask

    function automatic logic [7:0] pick_letter();
        case ($urandom_range(0, 3))
            0: return "a";
            1: return "b";
            2: return "A";
            default: return "B";
        endcase
    endfunction

    initial
    begin
        string s;
        int n;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Preload tables: phrase 0 is "ab", end slot 0 is NUL, slot 1 is 'Q'
        load_phrase(0, "ab");
        for (int p = 1; p < 16; p++)
        begin
            s = "";
            n = (p == 15) ? 6 : $urandom_range(1, 3);
            for (int k = 0; k < n; k++)
                s = {s, string'(pick_letter())};
            load_phrase(p, s);
        end
        queue_item(tpm_pkg::ACT_END_WR, 8'h00, 1'b0, 4'd0, 5'd0, 1'b0);
        queue_item(tpm_pkg::ACT_END_WR, "Q", 1'b0, 4'd1, 5'd0, 1'b0);
        wait_idle();

        // Directed: ignored input while off, folded match, end chars, timeout, restart
        write_all(0, 0, 256, 2, 2, 3);
        queue_char("a", 1'b1);
        queue_cmd(tpm_pkg::ACT_TICK);
        queue_cmd(tpm_pkg::ACT_START);
        queue_char("A", 1'b0);
        queue_char("B", 1'b1);
        queue_cmd(tpm_pkg::ACT_START);
        queue_char("q", 1'b0);
        queue_cmd(tpm_pkg::ACT_START);
        queue_char(8'hFF, 1'b0);
        queue_char(8'h00, 1'b0);
        queue_cmd(tpm_pkg::ACT_START);
        queue_cmd(tpm_pkg::ACT_TICK);
        queue_cmd(tpm_pkg::ACT_START);
        repeat (3) queue_cmd(tpm_pkg::ACT_TICK);
        queue_cmd(ACT_UNUSED);
        queue_cmd(ACT_UNUSED + 3'd2);
        wait_idle();

        // Zero limit never ends; small limit ends on a full buffer
        write_all(1, 1, 0, 16, 0, 0);
        queue_cmd(tpm_pkg::ACT_START);
        queue_char("x", 1'b1);
        wait_idle();
        write_reg(tpm_pkg::CFG_BUFFER_LIMIT, 3);
        queue_char("x", 1'b0);
        queue_char("y", 1'b1);
        queue_char("z", 1'b1);
        queue_char("w", 1'b0);
        wait_idle();

        // Lower the limit under the collected length while running
        write_all(0, 1, 5, 0, 2, TIMER_MAX);
        queue_cmd(tpm_pkg::ACT_START);
        repeat (4) queue_char("m", 1'b0);
        queue_cmd(tpm_pkg::ACT_TICK);
        wait_idle();
        write_reg(tpm_pkg::CFG_BUFFER_LIMIT, 2);
        queue_char("n", 1'b0);
        wait_idle();

        // Random phases: mostly well-formed runs of letters, some noise
        for (int ph = 0; ph < 3; ph++)
        begin
            write_all($urandom_range(0, 1), $urandom_range(0, 1),
                      ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12),
                      $urandom_range(0, 16),
                      $urandom_range(0, 2),
                      ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15));
            for (int k = 0; k < 10; k++)
            begin
                case ($urandom_range(0, 9))
                    0: queue_item(3'($urandom), 8'($urandom), 1'($urandom), 4'($urandom),
                                  5'($urandom), 1'($urandom));
                    1: queue_cmd(tpm_pkg::ACT_TICK);
                    2: queue_cmd(tpm_pkg::ACT_START);
                    3: queue_char(8'($urandom), 1'($urandom));
                    default: queue_char(pick_letter(), $urandom_range(0, 2) == 0);
                endcase
            end
            wait_idle();
        end

        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire

// ----- sim.f -----
rtl/tpm_pkg.sv
rtl/tpm_ram.sv
rtl/typed_text_phrase_matcher_core.sv
sim/tb_typed_text_phrase_matcher_core.sv
